/* rtl/pnc_pkg.sv */
// ============================================================================
// pnc_pkg: shared types and constants for the Perlin cell sample core
// Field widths of the pixel and noise words, gradient codes and queue depth.
// ============================================================================
package pnc_pkg;

    // Pixel word field widths
    localparam int OFFSET_W = 8;
    localparam int SIZE_W   = 4;
    localparam int LEVEL_W  = 4;
    localparam int GRAD_W   = 2;
    localparam int GRADS_W  = 8 * GRAD_W;

    // Noise word
    localparam int NOISE_W   = 19;
    localparam int OUT_MAX   = 262143;
    localparam int OUT_MIN   = -262144;

    // Two's complement codes of one gradient component
    localparam logic [GRAD_W-1:0] GRAD_ZERO = 2'b00;
    localparam logic [GRAD_W-1:0] GRAD_POS  = 2'b01;
    localparam logic [GRAD_W-1:0] GRAD_NEG2 = 2'b10;
    localparam logic [GRAD_W-1:0] GRAD_NEG  = 2'b11;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

endpackage

/* rtl/pnc_if.sv */
// ============================================================================
// pnc_if: stream channels of the Perlin cell sample core
// Pixel words in, noise words out; a word moves when valid and ready are high.
// ============================================================================
interface pnc_pix_if import pnc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic        [OFFSET_W-1:0] offset_x;
    logic        [OFFSET_W-1:0] offset_y;
    logic        [SIZE_W-1:0]   size_log2;
    logic        [LEVEL_W-1:0]  octave_level;
    logic signed [GRAD_W-1:0]   grad_a_x;
    logic signed [GRAD_W-1:0]   grad_a_y;
    logic signed [GRAD_W-1:0]   grad_b_x;
    logic signed [GRAD_W-1:0]   grad_b_y;
    logic signed [GRAD_W-1:0]   grad_c_x;
    logic signed [GRAD_W-1:0]   grad_c_y;
    logic signed [GRAD_W-1:0]   grad_d_x;
    logic signed [GRAD_W-1:0]   grad_d_y;

    modport source (
        output valid, offset_x, offset_y, size_log2, octave_level,
               grad_a_x, grad_a_y, grad_b_x, grad_b_y,
               grad_c_x, grad_c_y, grad_d_x, grad_d_y,
        input  ready
    );
    modport sink (
        input  valid, offset_x, offset_y, size_log2, octave_level,
               grad_a_x, grad_a_y, grad_b_x, grad_b_y,
               grad_c_x, grad_c_y, grad_d_x, grad_d_y,
        output ready
    );
endinterface

interface pnc_noise_if import pnc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [NOISE_W-1:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

/* rtl/pnc_front.sv */
// ============================================================================
// pnc_front: pixel word intake and classification
// Clamp the cell size, mask the offsets and form the Q fractions of the cell.
// ============================================================================
module pnc_front import pnc_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int MAX_SIZE_LOG2 = 8
) (
    pnc_pix_if.sink                i_pix,
    input  logic                   i_q_full,
    output logic                   o_push,
    output logic [FRAC_BITS-1:0]   o_tx,
    output logic [FRAC_BITS-1:0]   o_ty,
    output logic [LEVEL_W-1:0]     o_level,
    output logic [GRADS_W-1:0]     o_grads
);

    logic [SIZE_W-1:0]             size_sat;
    logic [OFFSET_W-1:0]           mask;
    logic [OFFSET_W-1:0]           ox;
    logic [OFFSET_W-1:0]           oy;
    logic [OFFSET_W+FRAC_BITS-1:0] x_wide;
    logic [OFFSET_W+FRAC_BITS-1:0] y_wide;

    assign i_pix.ready = !i_q_full;
    assign o_push      = i_pix.valid && !i_q_full;

    // Saturate oversized cells, then drop offset bits beyond the cell edge
    assign size_sat = (i_pix.size_log2 > SIZE_W'(MAX_SIZE_LOG2)) ?
                      SIZE_W'(MAX_SIZE_LOG2) : i_pix.size_log2;
    assign mask     = ~({OFFSET_W{1'b1}} << size_sat);
    assign ox       = i_pix.offset_x & mask;
    assign oy       = i_pix.offset_y & mask;

    // Fraction of the cell: offset / 2^size in Q.FRAC_BITS, always below one
    assign x_wide = {ox, {FRAC_BITS{1'b0}}} >> size_sat;
    assign y_wide = {oy, {FRAC_BITS{1'b0}}} >> size_sat;
    assign o_tx   = x_wide[FRAC_BITS-1:0];
    assign o_ty   = y_wide[FRAC_BITS-1:0];

    assign o_level = i_pix.octave_level;
    assign o_grads = {i_pix.grad_d_y, i_pix.grad_d_x, i_pix.grad_c_y, i_pix.grad_c_x,
                      i_pix.grad_b_y, i_pix.grad_b_x, i_pix.grad_a_y, i_pix.grad_a_x};

endmodule

/* rtl/pnc_queue.sv */
// ============================================================================
// pnc_queue: short word queue between front and back
// Register array with read and write pointers and a fill count.
// ============================================================================
module pnc_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [CW-1:0]     r_cnt;
    logic              do_push;
    logic              do_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // The front gates its push with full, so a push never meets a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("pnc_queue: push into full queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("pnc_queue: fill count did not advance on push");

endmodule

/* rtl/pnc_back.sv */
// ============================================================================
// pnc_back: noise arithmetic pipeline
// Corner dots, quintic fade, three lerps, octave shift and saturation.
// ============================================================================
module pnc_back import pnc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  logic [2*FRAC_BITS+LEVEL_W+GRADS_W-1:0] i_q_data,
    output logic                                 o_q_pop,
    pnc_noise_if.source                          o_noise
);

    localparam int F  = FRAC_BITS;
    localparam int QW = 2 * F + LEVEL_W + GRADS_W;
    localparam int DW = F + 4;     // corner dots
    localparam int PW = F + 5;     // fade polynomial term
    localparam int UW = F + 2;     // faded weights, 0..1
    localparam int LW = F + 5;     // row lerps and their spans
    localparam int MW = F + 6;     // vertical span and result
    localparam int SW = (MW > NOISE_W) ? MW : NOISE_W;

    localparam logic signed [DW-1:0] ONE_D     = DW'(1) << F;
    localparam logic signed [PW-1:0] FIFTEEN_P = PW'(15) << F;
    localparam logic signed [PW-1:0] TEN_P     = PW'(10) << F;
    localparam logic signed [UW-1:0] ONE_U     = UW'(1) << F;
    localparam logic signed [SW-1:0] SAT_MAX   = SW'(OUT_MAX);
    localparam logic signed [SW-1:0] SAT_MIN   = SW'(OUT_MIN);

    function automatic logic signed [DW-1:0] grad_term(
        input logic [GRAD_W-1:0] g, input logic signed [DW-1:0] d);
        unique case (g)
            GRAD_ZERO: grad_term = '0;
            GRAD_POS:  grad_term = d;
            GRAD_NEG:  grad_term = -d;
            GRAD_NEG2: grad_term = -(d <<< 1);
        endcase
    endfunction

    logic en;
    logic [4:0] r_vld;
    logic r_out_vld;
    logic signed [NOISE_W-1:0] r_noise;

    // Queue word fields
    logic [F-1:0]       q_tx, q_ty;
    logic [GRADS_W-1:0] q_grads;
    logic [LEVEL_W-1:0] q_level;

    assign q_tx    = i_q_data[F-1:0];
    assign q_ty    = i_q_data[2*F-1:F];
    assign q_grads = i_q_data[2*F+GRADS_W-1:2*F];
    assign q_level = i_q_data[QW-1:QW-LEVEL_W];

    // Advance the whole pipe unless a finished word waits at the output
    assign en      = !r_out_vld || o_noise.ready;
    assign o_q_pop = en && i_q_valid;

    // ---- stage 1: corner dots, t^2, t*(6t-15)+10
    logic signed [DW-1:0]    dx_p, dx_m, dy_p, dy_m;
    logic [2*F-1:0]          sq_x, sq_y;
    logic signed [PW-1:0]    lin_x, lin_y;
    logic signed [2*F+5:0]   prod_px, prod_py;
    logic signed [DW-1:0]    r_da1, r_db1, r_dc1, r_dd1;
    logic [F-1:0]            r_tx1, r_ty1, r_ttx1, r_tty1;
    logic signed [PW-1:0]    r_px1, r_py1;
    logic [LEVEL_W-1:0]      r_lvl1;

    assign dx_p    = DW'(q_tx);
    assign dy_p    = DW'(q_ty);
    assign dx_m    = dx_p - ONE_D;
    assign dy_m    = dy_p - ONE_D;
    assign sq_x    = q_tx * q_tx;
    assign sq_y    = q_ty * q_ty;
    assign lin_x   = PW'({q_tx, 2'b00}) + PW'({q_tx, 1'b0}) - FIFTEEN_P;
    assign lin_y   = PW'({q_ty, 2'b00}) + PW'({q_ty, 1'b0}) - FIFTEEN_P;
    assign prod_px = $signed({1'b0, q_tx}) * lin_x;
    assign prod_py = $signed({1'b0, q_ty}) * lin_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_da1  <= grad_term(q_grads[1:0], dx_p) + grad_term(q_grads[3:2], dy_p);
            r_db1  <= grad_term(q_grads[5:4], dx_m) + grad_term(q_grads[7:6], dy_p);
            r_dc1  <= grad_term(q_grads[9:8], dx_p) + grad_term(q_grads[11:10], dy_m);
            r_dd1  <= grad_term(q_grads[13:12], dx_m) + grad_term(q_grads[15:14], dy_m);
            r_tx1  <= q_tx;
            r_ty1  <= q_ty;
            r_ttx1 <= sq_x[2*F-1:F];
            r_tty1 <= sq_y[2*F-1:F];
            r_px1  <= PW'(prod_px >>> F) + TEN_P;
            r_py1  <= PW'(prod_py >>> F) + TEN_P;
            r_lvl1 <= q_level;
        end
    end

    // ---- stage 2: t^3
    logic [2*F-1:0]       cube_x, cube_y;
    logic [F-1:0]         r_fx2, r_fy2;
    logic signed [PW-1:0] r_px2, r_py2;
    logic signed [DW-1:0] r_da2, r_db2, r_dc2, r_dd2;
    logic [LEVEL_W-1:0]   r_lvl2;

    assign cube_x = r_ttx1 * r_tx1;
    assign cube_y = r_tty1 * r_ty1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx2  <= cube_x[2*F-1:F];
            r_fy2  <= cube_y[2*F-1:F];
            r_px2  <= r_px1;
            r_py2  <= r_py1;
            r_da2  <= r_da1;
            r_db2  <= r_db1;
            r_dc2  <= r_dc1;
            r_dd2  <= r_dd1;
            r_lvl2 <= r_lvl1;
        end
    end

    // ---- stage 3: fade weights and row spans
    logic signed [2*F+5:0] prod_ux, prod_uy;
    logic signed [UW-1:0]  r_u3, r_v3;
    logic signed [DW-1:0]  r_da3, r_dc3;
    logic signed [LW-1:0]  r_dtop3, r_dbot3;
    logic [LEVEL_W-1:0]    r_lvl3;

    assign prod_ux = $signed({1'b0, r_fx2}) * r_px2;
    assign prod_uy = $signed({1'b0, r_fy2}) * r_py2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u3    <= UW'(prod_ux >>> F);
            r_v3    <= UW'(prod_uy >>> F);
            r_da3   <= r_da2;
            r_dc3   <= r_dc2;
            r_dtop3 <= LW'(r_db2) - LW'(r_da2);
            r_dbot3 <= LW'(r_dd2) - LW'(r_dc2);
            r_lvl3  <= r_lvl2;
        end
    end

    // ---- stage 4: horizontal lerps
    logic signed [UW+LW-1:0] prod_top, prod_bot;
    logic signed [LW-1:0]    r_top4, r_bot4;
    logic signed [UW-1:0]    r_v4;
    logic [LEVEL_W-1:0]      r_lvl4;

    assign prod_top = r_u3 * r_dtop3;
    assign prod_bot = r_u3 * r_dbot3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_top4 <= LW'(r_da3) + LW'(prod_top >>> F);
            r_bot4 <= LW'(r_dc3) + LW'(prod_bot >>> F);
            r_v4   <= r_v3;
            r_lvl4 <= r_lvl3;
        end
    end

    // ---- stage 5: vertical lerp
    logic signed [MW-1:0]    span_v;
    logic signed [UW+MW-1:0] prod_n;
    logic signed [MW-1:0]    r_n5;
    logic [LEVEL_W-1:0]      r_lvl5;

    assign span_v = MW'(r_bot4) - MW'(r_top4);
    assign prod_n = r_v4 * span_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n5   <= MW'(r_top4) + MW'(prod_n >>> F);
            r_lvl5 <= r_lvl4;
        end
    end

    // ---- stage 6: octave shift, saturate into the output register
    logic signed [SW-1:0]      n_ext, n_shift;
    logic signed [NOISE_W-1:0] n_noise;

    assign n_ext   = SW'(r_n5);
    assign n_shift = n_ext >>> r_lvl5;

    always_comb begin
        priority if (n_shift > SAT_MAX) begin
            n_noise = NOISE_W'(SAT_MAX);
        end else if (n_shift < SAT_MIN) begin
            n_noise = NOISE_W'(SAT_MIN);
        end else begin
            n_noise = NOISE_W'(n_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_noise <= n_noise;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[3:0], i_q_valid};
            r_out_vld <= r_vld[4];
        end
    end

    assign o_noise.valid       = r_out_vld;
    assign o_noise.noise_value = r_noise;

    // A waiting output word freezes every stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_noise.ready) |=> $stable(r_vld))
        else $error("pnc_back: pipeline moved during output stall");

    // Fade weights stay within zero and one
    a_fade_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_u3 >= 0 && r_u3 <= ONE_U && r_v3 >= 0 && r_v3 <= ONE_U))
        else $error("pnc_back: fade weight out of range");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_vld[4]))
        else $error("pnc_back: output word without a last-stage word");

endmodule

/* rtl/perlin_noise_cell_sample_core.sv */
// ============================================================================
// perlin_noise_cell_sample_core: one octave of 2-D Perlin noise per pixel
// Front classifies pixel words into a short queue; the back pipeline turns
// each into a saturated, octave-scaled noise word.
// ============================================================================
//
//  port      dir  word         handshake      content
//  --------  ---  -----------  -------------  --------------------------------
//  i_pix     in   pixel word   valid / ready  offsets, cell size, octave,
//                                             four corner gradients
//  o_noise   out  noise word   valid / ready  signed Q3.16 noise contribution
//
//  Throughput is one word per cycle while noise words are taken. A pixel word
//  that is accepted passes the queue write, then five arithmetic stages and
//  the output register, a depth set by the multiplier chain of the fade and
//  the three lerps.
//  i_rst_n is synchronous and clears the queue count and pipeline valids.
//  A noise word that is not taken freezes the back pipeline; the queue keeps
//  accepting pixel words until it holds QUEUE_DEPTH of them.
//
module perlin_noise_cell_sample_core import pnc_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int MAX_SIZE_LOG2 = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pnc_pix_if.sink      i_pix,
    pnc_noise_if.source  o_noise
);

    // Queue word: level, gradients, ty, tx (tx in the low bits)
    localparam int QW = 2 * FRAC_BITS + LEVEL_W + GRADS_W;

    logic                 push;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic [FRAC_BITS-1:0] tx, ty;
    logic [LEVEL_W-1:0]   level;
    logic [GRADS_W-1:0]   grads;
    logic [QW-1:0]        q_wdata;
    logic [QW-1:0]        q_rdata;

    // Front: clamp size, mask offsets, form the cell fractions
    pnc_front #(
        .FRAC_BITS     (FRAC_BITS),
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_front (
        .i_pix    (i_pix),
        .i_q_full (q_full),
        .o_push   (push),
        .o_tx     (tx),
        .o_ty     (ty),
        .o_level  (level),
        .o_grads  (grads)
    );

    assign q_wdata = {level, grads, ty, tx};

    // Decouple intake from the arithmetic so each side can stall on its own
    pnc_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // Back: dots, fade, lerps, octave shift, saturation, output register
    pnc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_noise   (o_noise)
    );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench for perlin_noise_cell_sample_core
// Streams pixel words into the core: a short table of directed rows, then
// random rows. Every noise word is compared in order against a typed-in value or
// a software prediction of the fixed-point Perlin contribution. Both channels idle at
// random; a long receiver hold-off and a drain pause stress the queue.
// ============================================================================
module tb_top import pnc_pkg::*; ();

    // Arithmetic settings of the core under test
    localparam int     FRAC     = 16;
    localparam int     MAX_SIZE = 8;
    localparam longint ONE_Q    = 64'sd1 <<< FRAC;

    // Run shape
    localparam int RANDOM_WORDS  = 600;
    localparam int HOLDOFF_AT    = 150;   // random word count that starts the hold-off
    localparam int HOLDOFF_LEN   = 80;    // receiver cycles held off
    localparam int DRAIN_AT      = 300;   // random word preceded by a full drain
    localparam int CALM_FROM     = 400;   // stretch with no idling on either side
    localparam int CALM_TO       = 520;
    localparam int IDLE_PCT      = 6;
    localparam int TAIL_CYCLES   = 16;    // a margin over the pipeline latency
    localparam int STALL_LIMIT   = 2000;  // cycles with no word moving

    typedef struct {
        logic        [OFFSET_W-1:0] offset_x;
        logic        [OFFSET_W-1:0] offset_y;
        logic        [SIZE_W-1:0]   size_log2;
        logic        [LEVEL_W-1:0]  octave_level;
        logic signed [GRAD_W-1:0]   grad_a_x;
        logic signed [GRAD_W-1:0]   grad_a_y;
        logic signed [GRAD_W-1:0]   grad_b_x;
        logic signed [GRAD_W-1:0]   grad_b_y;
        logic signed [GRAD_W-1:0]   grad_c_x;
        logic signed [GRAD_W-1:0]   grad_c_y;
        logic signed [GRAD_W-1:0]   grad_d_x;
        logic signed [GRAD_W-1:0]   grad_d_y;
    } t_pix_word;

    // One row of stimulus: the pixel word, an optional typed-in noise value,
    // and whether the sender must wait for every noise word before it.
    typedef struct {
        t_pix_word                 pix;
        bit                        typed;
        logic signed [NOISE_W-1:0] typed_noise;
        bit                        drain;
    } t_pix_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pnc_pix_if   pix ();
    pnc_noise_if noise ();

    perlin_noise_cell_sample_core #(
        .FRAC_BITS     (FRAC),
        .MAX_SIZE_LOG2 (MAX_SIZE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_noise (noise)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_pix_row                  pix_rows_q[$];       // rows not yet accepted
    logic signed [NOISE_W-1:0] noise_expect_q[$];   // noise words still owed
    t_pix_row                  next_row;

    int  n_directed;
    int  n_rows;
    int  words_sent     = 0;
    int  words_checked  = 0;
    int  mismatches     = 0;
    int  clamped_words  = 0;
    int  negative_words = 0;
    int  holdoff_left   = 0;
    bit  holdoff_done   = 1'b0;
    int  stall_cycles   = 0;

    // No idling on either side for a stretch in the middle of the random part
    wire calm = (words_sent >= n_directed + CALM_FROM) && (words_sent < n_directed + CALM_TO);

    // ------------------------------------------------------------------------
    // Prediction: Q.FRAC fixed point, every product floored by >>>
    // ------------------------------------------------------------------------
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    // Quintic fade 6t^5 - 15t^4 + 10t^3, evaluated in the core's order
    function automatic longint quintic_fade(longint t);
        longint p;
        longint f;
        p = qmul(t, 6 * t - 15 * ONE_Q) + 10 * ONE_Q;
        f = qmul(qmul(t, t), t);
        return qmul(f, p);
    endfunction

    function automatic longint blend(longint a, longint b, longint w);
        return a + qmul(w, b - a);
    endfunction

    function automatic logic signed [NOISE_W-1:0] cell_noise(t_pix_word w);
        int     s;
        longint ox, oy, tx, ty, dxm, dym;
        longint da, db, dc, dd, u, v, top, bot, n;
        // Clamp oversized cells, then drop offset bits outside the cell
        s   = (w.size_log2 > MAX_SIZE) ? MAX_SIZE : int'(w.size_log2);
        ox  = longint'(w.offset_x) & ((64'sd1 << s) - 1);
        oy  = longint'(w.offset_y) & ((64'sd1 << s) - 1);
        tx  = (ox << FRAC) >> s;
        ty  = (oy << FRAC) >> s;
        dxm = tx - ONE_Q;
        dym = ty - ONE_Q;
        // Gradient fields are signed, so the 10 pattern reads as -2
        da  = longint'(w.grad_a_x) * tx  + longint'(w.grad_a_y) * ty;
        db  = longint'(w.grad_b_x) * dxm + longint'(w.grad_b_y) * ty;
        dc  = longint'(w.grad_c_x) * tx  + longint'(w.grad_c_y) * dym;
        dd  = longint'(w.grad_d_x) * dxm + longint'(w.grad_d_y) * dym;
        u   = quintic_fade(tx);
        v   = quintic_fade(ty);
        top = blend(da, db, u);
        bot = blend(dc, dd, u);
        n   = blend(top, bot, v) >>> w.octave_level;
        if (n > OUT_MAX) n = OUT_MAX;
        if (n < OUT_MIN) n = OUT_MIN;
        return n[NOISE_W-1:0];
    endfunction

    // Append one directed row; grads packs a_x..d_y from the top, two bits each
    task automatic add_row(input int ox, input int oy, input int s, input int lvl,
                           input logic [15:0] grads, input bit typed,
                           input int noise_val);
        t_pix_row r;
        r.pix.offset_x     = OFFSET_W'(ox);
        r.pix.offset_y     = OFFSET_W'(oy);
        r.pix.size_log2    = SIZE_W'(s);
        r.pix.octave_level = LEVEL_W'(lvl);
        r.pix.grad_a_x     = grads[15:14];
        r.pix.grad_a_y     = grads[13:12];
        r.pix.grad_b_x     = grads[11:10];
        r.pix.grad_b_y     = grads[9:8];
        r.pix.grad_c_x     = grads[7:6];
        r.pix.grad_c_y     = grads[5:4];
        r.pix.grad_d_x     = grads[3:2];
        r.pix.grad_d_y     = grads[1:0];
        r.typed            = typed;
        r.typed_noise      = NOISE_W'(noise_val);
        r.drain            = 1'b0;
        pix_rows_q = {pix_rows_q, r};
    endtask

    // ------------------------------------------------------------------------
    // Pixel sender: hold a word until it is taken, idle only between words
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid        <= 1'b0;
            pix.offset_x     <= '0;
            pix.offset_y     <= '0;
            pix.size_log2    <= '0;
            pix.octave_level <= '0;
            pix.grad_a_x     <= '0;
            pix.grad_a_y     <= '0;
            pix.grad_b_x     <= '0;
            pix.grad_b_y     <= '0;
            pix.grad_c_x     <= '0;
            pix.grad_c_y     <= '0;
            pix.grad_d_x     <= '0;
            pix.grad_d_y     <= '0;
        end else begin
            if (pix.valid && pix.ready) begin
                next_row = pix_rows_q.pop_front();
                if (next_row.typed) begin
                    noise_expect_q = {noise_expect_q, next_row.typed_noise};
                end else begin
                    noise_expect_q = {noise_expect_q, cell_noise(next_row.pix)};
                end
                if (noise_expect_q[$] == OUT_MAX || noise_expect_q[$] == OUT_MIN)
                    clamped_words++;
                if (noise_expect_q[$] < 0)
                    negative_words++;
                words_sent++;
            end
            // A word still on offer stays as it is
            if (!(pix.valid && !pix.ready)) begin
                if (pix_rows_q.size() > 0
                        && !(pix_rows_q[0].drain && noise_expect_q.size() > 0)
                        && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    next_row         = pix_rows_q[0];
                    pix.valid        <= 1'b1;
                    pix.offset_x     <= next_row.pix.offset_x;
                    pix.offset_y     <= next_row.pix.offset_y;
                    pix.size_log2    <= next_row.pix.size_log2;
                    pix.octave_level <= next_row.pix.octave_level;
                    pix.grad_a_x     <= next_row.pix.grad_a_x;
                    pix.grad_a_y     <= next_row.pix.grad_a_y;
                    pix.grad_b_x     <= next_row.pix.grad_b_x;
                    pix.grad_b_y     <= next_row.pix.grad_b_y;
                    pix.grad_c_x     <= next_row.pix.grad_c_x;
                    pix.grad_c_y     <= next_row.pix.grad_c_y;
                    pix.grad_d_x     <= next_row.pix.grad_d_x;
                    pix.grad_d_y     <= next_row.pix.grad_d_y;
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Noise receiver: check each word in order, stall at random, and once
    // hold off long enough for the core's queue to fill and stall its input
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            noise.ready <= 1'b0;
        end else begin
            if (noise.valid && noise.ready) begin
                if (noise_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] noise word %0d arrived with nothing expected",
                                 $time, noise.noise_value);
                end else begin
                    if (noise.noise_value !== noise_expect_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] noise word %0d: expected %0d, got %0d",
                                     $time, words_checked, noise_expect_q[0],
                                     noise.noise_value);
                    end
                    void'(noise_expect_q.pop_front());
                    words_checked++;
                end
            end
            if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                noise.ready  <= 1'b0;
            end else if (!holdoff_done && words_sent >= n_directed + HOLDOFF_AT) begin
                holdoff_left <= HOLDOFF_LEN;
                holdoff_done <= 1'b1;
                noise.ready  <= 1'b0;
            end else begin
                noise.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pix.valid && pix.ready) || (noise.valid && noise.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        t_pix_row r;
        int       k;

        i_rst_n = 1'b0;

        // Directed table. Typed rows sit on the top-left corner, where its dot and
        // both fade weights vanish and the noise is zero whatever the gradients.
        add_row(  0,   0,  0,  0, 16'h0000, 1'b1, 0);
        add_row(255, 255,  0,  0, 16'hFFFF, 1'b1, 0);   // unit cell masks offsets away
        add_row(  0,   0,  8, 15, 16'hAAAA, 1'b1, 0);
        add_row(  0,   0, 15,  0, 16'h5555, 1'b1, 0);   // oversized cell, origin
        add_row(  0, 255,  8,  0, 16'h5555, 1'b0, 0);
        add_row(255,   0,  8,  0, 16'hFFFF, 1'b0, 0);
        add_row(255, 255, 15,  0, 16'h5555, 1'b0, 0);   // oversized cell clamps to 8
        add_row(255, 255,  8,  0, 16'hFFFF, 1'b0, 0);
        add_row(248,  19,  4,  3, 16'h1D7B, 1'b0, 0);   // offsets spill past the cell
        add_row(  1,   1,  1,  0, 16'h5A5F, 1'b0, 0);
        add_row(128, 128,  8,  0, 16'h5B6A, 1'b0, 0);   // center, steepest mix
        add_row(128, 128,  8,  0, 16'hA9E5, 1'b0, 0);
        add_row(200,  56,  8,  0, 16'hAAAA, 1'b0, 0);   // -2 gradients, hunting the clamp
        add_row( 56, 200,  8,  0, 16'hAAAA, 1'b0, 0);
        add_row(230, 230,  8,  0, 16'h5B6A, 1'b0, 0);
        add_row( 25,  25,  8,  0, 16'hA9E5, 1'b0, 0);
        add_row(192,  64,  8,  0, 16'h6AA6, 1'b0, 0);
        add_row(100, 160,  8, 15, 16'h5B6A, 1'b0, 0);   // deepest octave
        add_row(100, 160,  8,  1, 16'hFFFF, 1'b0, 0);
        add_row(  1,   1,  2,  0, 16'h5000, 1'b0, 0);   // one corner at a time
        add_row(  1,   1,  2,  0, 16'h0500, 1'b0, 0);
        add_row(  1,   1,  2,  0, 16'h0050, 1'b0, 0);
        add_row(  1,   1,  2,  0, 16'h0005, 1'b0, 0);
        n_directed = pix_rows_q.size();

        // Random rows: mostly legal cells and gradients, now and then the
        // oversized cell codes and the -2 gradient pattern
        for (k = 0; k < RANDOM_WORDS; k++) begin
            r.pix.offset_x     = OFFSET_W'($urandom_range(255));
            r.pix.offset_y     = OFFSET_W'($urandom_range(255));
            r.pix.size_log2    = SIZE_W'(($urandom_range(9) == 0) ? $urandom_range(15)
                                                                  : $urandom_range(MAX_SIZE));
            r.pix.octave_level = LEVEL_W'(($urandom_range(3) == 0) ? $urandom_range(15)
                                                                   : $urandom_range(3));
            r.pix.grad_a_x = GRAD_W'(($urandom_range(9) < 7) ? $urandom_range(2) - 1
                                                             : $urandom_range(3));
            r.pix.grad_a_y = GRAD_W'(($urandom_range(9) < 7) ? $urandom_range(2) - 1
                                                             : $urandom_range(3));
            r.pix.grad_b_x = GRAD_W'(($urandom_range(9) < 7) ? $urandom_range(2) - 1
                                                             : $urandom_range(3));
            r.pix.grad_b_y = GRAD_W'(($urandom_range(9) < 7) ? $urandom_range(2) - 1
                                                             : $urandom_range(3));
            r.pix.grad_c_x = GRAD_W'(($urandom_range(9) < 7) ? $urandom_range(2) - 1
                                                             : $urandom_range(3));
            r.pix.grad_c_y = GRAD_W'(($urandom_range(9) < 7) ? $urandom_range(2) - 1
                                                             : $urandom_range(3));
            r.pix.grad_d_x = GRAD_W'(($urandom_range(9) < 7) ? $urandom_range(2) - 1
                                                             : $urandom_range(3));
            r.pix.grad_d_y = GRAD_W'(($urandom_range(9) < 7) ? $urandom_range(2) - 1
                                                             : $urandom_range(3));
            r.typed        = 1'b0;
            r.typed_noise  = '0;
            r.drain        = (k == DRAIN_AT);
            pix_rows_q = {pix_rows_q, r};
        end
        n_rows = pix_rows_q.size();

        // Synchronous reset, released once
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to go in and every noise word to come back,
        // then give the pipeline a few more cycles to show any stray word
        while (!(words_sent == n_rows && noise_expect_q.size() == 0))
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d pixel words (%0d directed), %0d noise words checked",
                 words_sent, n_directed, words_checked);
        $display("%0d negative and %0d clamped noise words, one hold-off, one drain",
                 negative_words, clamped_words);
        if (mismatches == 0 && noise_expect_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/pnc_pkg.sv
rtl/pnc_if.sv
rtl/pnc_front.sv
rtl/pnc_queue.sv
rtl/pnc_back.sv
rtl/perlin_noise_cell_sample_core.sv
verif/tb_top.sv
